// ===== design/agrmd_pkg.sv =====
// Shared types and constants for the accelerometer gravity removal and motion detect block.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package agrmd_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int FILT_W     = 11;
    localparam int WEIGHT_W   = 4;
    localparam int THRESH_W   = 7;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NUM_AXES   = 3;

    // gravity update arithmetic: weighted sum and its magnitude
    localparam int ACC_W = 14;
    localparam int MAG_W = 13;

    // divide by ten as multiply by reciprocal, exact for magnitudes below 16384
    localparam int DIV10_SHIFT = 16;
    localparam int DIV10_MUL_W = 13;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;

    localparam logic [WEIGHT_W-1:0] NORM_DIV = 4'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

    // register limits and reset values
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN   = 4'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 4'd9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd6;
    localparam logic [THRESH_W-1:0] THRESH_MIN   = 7'd1;
    localparam logic [THRESH_W-1:0] THRESH_MAX   = 7'd100;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd40;

    localparam logic signed [SAMPLE_W-1:0] PRIOR_RESET = 10'sd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [FILT_W-1:0]   filt_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_X    = 2'd0,
        ACT_Y    = 2'd1,
        ACT_Z    = 2'd2,
        ACT_SYNC = 2'd3
    } action_t;

    // per-axis result of one sync
    typedef struct packed {
        filt_t filt;
        logic  above;
        logic  below;
    } axis_res_t;

endpackage

`default_nettype wire

// ===== design/agrmd_if.sv =====
// Valid/ready channel interfaces: axis events in, motion results out, register writes.
// Depends on agrmd_pkg for field widths and types.
`default_nettype none

interface agrmd_in_if;
    logic                             valid;
    logic                             ready;
    logic [agrmd_pkg::ACTION_W-1:0]   action;
    logic signed [agrmd_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output action, output sample_value, input ready);
    modport sink   (input valid, input action, input sample_value, output ready);
endinterface

interface agrmd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [agrmd_pkg::FILT_W-1:0] filtered_x;
    logic signed [agrmd_pkg::FILT_W-1:0] filtered_y;
    logic signed [agrmd_pkg::FILT_W-1:0] filtered_z;
    logic                              move_left;
    logic                              move_right;
    logic                              move_backward;
    logic                              move_forward;
    logic                              move_down;
    logic                              move_up;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    output move_left, output move_right, output move_backward,
                    output move_forward, output move_down, output move_up, input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    input move_left, input move_right, input move_backward,
                    input move_forward, input move_down, input move_up, output ready);
endinterface

interface agrmd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [agrmd_pkg::CFG_IDX_W-1:0]    index;
    logic [agrmd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/agrmd_axis_filter.sv =====
// One axis lane: low-pass gravity update, gravity subtraction and threshold compare.
// Depends on agrmd_pkg; purely combinational, instantiated once per axis by the top level.
`default_nettype none

module agrmd_axis_filter (
    input  wire logic [agrmd_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [agrmd_pkg::THRESH_W-1:0] thresh,
    input  wire agrmd_pkg::sample_t             gravity,
    input  wire agrmd_pkg::sample_t             prior,
    input  wire agrmd_pkg::sample_t             current,
    output agrmd_pkg::sample_t                  gravity_new,
    output agrmd_pkg::axis_res_t                res
);

    localparam int ACC_W  = agrmd_pkg::ACC_W;
    localparam int MAG_W  = agrmd_pkg::MAG_W;
    localparam int SMP_W  = agrmd_pkg::SAMPLE_W;
    localparam int FLT_W  = agrmd_pkg::FILT_W;
    localparam int WGT_W  = agrmd_pkg::WEIGHT_W;
    localparam int PROD_W = MAG_W + agrmd_pkg::DIV10_MUL_W;

    logic [WGT_W-1:0]        weight_new;
    logic signed [ACC_W-1:0] weight_s;
    logic signed [ACC_W-1:0] weight_new_s;
    logic signed [ACC_W-1:0] gravity_s;
    logic signed [ACC_W-1:0] prior_s;
    logic signed [ACC_W-1:0] mix_sum;
    logic signed [ACC_W-1:0] mix_neg;
    logic                    mix_is_neg;
    logic [MAG_W-1:0]        mix_mag;
    logic [PROD_W-1:0]       quot_prod;
    logic [SMP_W-1:0]        quot_mag;
    logic signed [FLT_W-1:0] thresh_s;
    agrmd_pkg::filt_t        filt;

    // weighted mix of old gravity and prior sample
    assign weight_new   = agrmd_pkg::NORM_DIV - weight;
    assign weight_s     = $signed({{(ACC_W-WGT_W){1'b0}}, weight});
    assign weight_new_s = $signed({{(ACC_W-WGT_W){1'b0}}, weight_new});
    assign gravity_s    = {{(ACC_W-SMP_W){gravity[SMP_W-1]}}, gravity};
    assign prior_s      = {{(ACC_W-SMP_W){prior[SMP_W-1]}}, prior};
    assign mix_sum      = weight_s * gravity_s + weight_new_s * prior_s;

    // divide by ten truncating toward zero: work on the magnitude
    assign mix_is_neg = mix_sum[ACC_W-1];
    assign mix_neg    = -mix_sum;
    assign mix_mag    = mix_is_neg ? mix_neg[MAG_W-1:0] : mix_sum[MAG_W-1:0];
    assign quot_prod  = PROD_W'(mix_mag) * PROD_W'(agrmd_pkg::DIV10_MUL);
    assign quot_mag   = quot_prod[agrmd_pkg::DIV10_SHIFT +: SMP_W];

    // mix stays within the sample range, so no clamp is needed
    assign gravity_new = mix_is_neg ? $signed(-quot_mag) : $signed(quot_mag);

    // gravity removal and direction compare
    assign filt     = {current[SMP_W-1], current} - {gravity_new[SMP_W-1], gravity_new};
    assign thresh_s = $signed({{(FLT_W-agrmd_pkg::THRESH_W){1'b0}}, thresh});

    assign res.filt  = filt;
    assign res.above = (filt > thresh_s);
    assign res.below = (filt < -thresh_s);

endmodule

`default_nettype wire

// ===== design/accel_gravity_removal_motion_detect_unit.sv =====
// Top level of the accelerometer gravity removal and motion detect block.
// Depends on agrmd_pkg, the channel interfaces in agrmd_if.sv and agrmd_axis_filter.
`default_nettype none

// Axis events (x, y, z) latch a signed 10-bit reading; a sync event updates a per-axis
// gravity estimate grav = (w*grav + (10-w)*prior)/10, subtracts it from the latched
// readings and returns one result with the three filtered values and six direction flags
// (filtered above +threshold or below -threshold). Axis events return nothing. Every
// transfer passes through the input register; a sync then loads its result into the output
// register. One event is taken per clock, limited only by the output register being full
// with a sync pending. Register writes with an unknown index, a threshold outside 1..100
// or a weight outside 1..9 are dropped; the weight is the low 4 data bits, so higher bits
// are ignored. The write channel is always ready.
module accel_gravity_removal_motion_detect_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    agrmd_in_if.sink          in_ch,
    agrmd_out_if.source       out_ch,
    agrmd_cfg_if.sink         cfg
);

    localparam int NUM_AXES = agrmd_pkg::NUM_AXES;

    // configuration
    logic [agrmd_pkg::WEIGHT_W-1:0] weight_reg;
    logic [agrmd_pkg::THRESH_W-1:0] thresh_reg;
    logic [agrmd_pkg::WEIGHT_W-1:0] cfg_weight;
    logic [agrmd_pkg::THRESH_W-1:0] cfg_thresh;

    // input register stage
    logic                  s1_valid_reg;
    agrmd_pkg::action_t    s1_action_reg;
    agrmd_pkg::sample_t    s1_sample_reg;
    logic                  s1_is_sync;
    logic                  s1_go;
    logic                  s1_fire;
    logic                  out_load;

    // per-axis state
    agrmd_pkg::sample_t    latched_reg [NUM_AXES];
    agrmd_pkg::sample_t    prior_reg   [NUM_AXES];
    agrmd_pkg::sample_t    grav_reg    [NUM_AXES];
    agrmd_pkg::sample_t    grav_next   [NUM_AXES];
    agrmd_pkg::axis_res_t  axis_res    [NUM_AXES];

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    agrmd_pkg::axis_res_t  out_res_reg [NUM_AXES];

    // register writes
    assign cfg.ready  = 1'b1;
    assign cfg_weight = cfg.data[agrmd_pkg::WEIGHT_W-1:0];
    assign cfg_thresh = cfg.data[agrmd_pkg::THRESH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= agrmd_pkg::WEIGHT_RESET;
            thresh_reg <= agrmd_pkg::THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == agrmd_pkg::REG_WEIGHT &&
                cfg_weight >= agrmd_pkg::WEIGHT_MIN && cfg_weight <= agrmd_pkg::WEIGHT_MAX)
            begin
                weight_reg <= cfg_weight;
            end
            if (cfg.index == agrmd_pkg::REG_THRESH &&
                cfg_thresh >= agrmd_pkg::THRESH_MIN && cfg_thresh <= agrmd_pkg::THRESH_MAX)
            begin
                thresh_reg <= cfg_thresh;
            end
        end
    end

    // stage handshake: only a sync needs room in the output register
    assign s1_is_sync = (s1_action_reg == agrmd_pkg::ACT_SYNC);
    assign s1_go      = !s1_is_sync || !out_valid_reg || out_ch.ready;
    assign s1_fire    = s1_valid_reg && s1_go;
    assign out_load   = s1_fire && s1_is_sync;
    assign in_ch.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_action_reg <= agrmd_pkg::action_t'(in_ch.action);
            s1_sample_reg <= in_ch.sample_value;
        end
    end

    // axis lanes
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        agrmd_axis_filter u_axis (
            .weight      (weight_reg),
            .thresh      (thresh_reg),
            .gravity     (grav_reg[a]),
            .prior       (prior_reg[a]),
            .current     (latched_reg[a]),
            .gravity_new (grav_next[a]),
            .res         (axis_res[a])
        );

        // latch readings, advance gravity and prior on sync
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                latched_reg[a] <= '0;
                prior_reg[a]   <= agrmd_pkg::PRIOR_RESET;
                grav_reg[a]    <= '0;
            end
            else if (s1_fire)
            begin
                if (s1_is_sync)
                begin
                    grav_reg[a]  <= grav_next[a];
                    prior_reg[a] <= latched_reg[a];
                end
                else if (s1_action_reg == agrmd_pkg::action_t'(a))
                begin
                    latched_reg[a] <= s1_sample_reg;
                end
            end
        end

        // result payload
        always_ff @(posedge clk)
        begin
            if (out_load)
            begin
                out_res_reg[a] <= axis_res[a];
            end
        end
    end

    // output valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result fields
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.filtered_x    = out_res_reg[0].filt;
    assign out_ch.filtered_y    = out_res_reg[1].filt;
    assign out_ch.filtered_z    = out_res_reg[2].filt;
    assign out_ch.move_left     = out_res_reg[0].above;
    assign out_ch.move_right    = out_res_reg[0].below;
    assign out_ch.move_backward = out_res_reg[1].above;
    assign out_ch.move_forward  = out_res_reg[1].below;
    assign out_ch.move_down     = out_res_reg[2].above;
    assign out_ch.move_up       = out_res_reg[2].below;

endmodule

`default_nettype wire
